// ----- src/rpd_pkg.sv -----
// Shared types, constants and the CRC-8 helper for the RS-485 packet deframer.
// No dependencies; every other file in src refers to this package by scoped names.
package rpd_pkg;

    // Receive buffer depth of the firmware this block mirrors
    localparam int RX_BUFFER_SIZE = 1024;
    // Packet length must stay below this
    localparam logic [16:0] LEN_LIMIT = 17'(RX_BUFFER_SIZE - 6);
    localparam logic [15:0] LEN_FLOOR = 16'd8;

    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam logic [7:0] ID_BASE   = 8'h10;
    localparam logic [7:0] BCAST_ADR = 8'hFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_HDR_BAD   = 3'd1;
    localparam logic [2:0] ST_LEN_BAD   = 3'd2;
    localparam logic [2:0] ST_NO_END    = 3'd3;
    localparam logic [2:0] ST_CRC_BAD   = 3'd4;
    localparam logic [2:0] ST_NOT_ADDR  = 3'd5;

    typedef struct packed {
        logic [7:0]  unit_id;
        logic [7:0]  own_address;
        logic [15:0] min_packet_length;
        logic [7:0]  end_code;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  sender_address;
        logic        is_broadcast;
        logic [15:0] packet_length;
    } result_t;

    // One byte of reflected CRC-8, polynomial 0x8C
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] x;
        x = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ----- src/rs485_packet_deframer_crc8.sv -----
// RS-485 packet deframer with Dallas/Maxim CRC-8 header and packet checks.
// Throughput: one byte item per cycle, sustained while the result side keeps up.
// A status item for a packet's last byte passes the input register, then the result register
// (the CRC byte update sits between them), and moves on only while the result register is free
// or being taken.
// Reset (rst_n low, asynchronous) empties both registers, returns the tracker to idle
// and loads the configuration defaults: unit_id 0, own_address 1, min length 9, end code 4.
module rs485_packet_deframer_crc8 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [7:0]                    sender_address,
    output logic                          is_broadcast,
    output logic [15:0]                   packet_length,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    rpd_pkg::cfg_t    cfg;
    rpd_pkg::item_t   in_item;
    rpd_pkg::item_t   s1_item;
    rpd_pkg::result_t res;
    rpd_pkg::result_t out_res;
    logic             s1_valid;
    logic             advance;
    logic             res_valid;
    logic             fire;

    assign cfg_ready = 1'b1;

    assign in_item.rx_byte     = rx_byte;
    assign in_item.frame_start = frame_start;

    assign fire = s1_valid && advance;

    rpd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rpd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    rpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    rpd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status         = out_res.status;
    assign sender_address = out_res.sender_address;
    assign is_broadcast   = out_res.is_broadcast;
    assign packet_length  = out_res.packet_length;

endmodule

// ----- src/rpd_cfg.sv -----
// Configuration register file of the packet deframer.
// Depends on rpd_pkg for the register indexes and the cfg_t struct.
module rpd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [rpd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]                   wr_data,
    output rpd_pkg::cfg_t                 cfg
);

    rpd_pkg::cfg_t cfg_reg;
    rpd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                rpd_pkg::CFG_UNIT_ID:  cfg_next.unit_id           = wr_data[7:0];
                rpd_pkg::CFG_OWN_ADDR: cfg_next.own_address       = wr_data[7:0];
                rpd_pkg::CFG_MIN_LEN:  cfg_next.min_packet_length = wr_data;
                rpd_pkg::CFG_END_CODE: cfg_next.end_code          = wr_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_id           <= 8'd0;
            cfg_reg.own_address       <= 8'd1;
            cfg_reg.min_packet_length <= 16'd9;
            cfg_reg.end_code          <= 8'd4;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/rpd_in_stage.sv -----
// Input register of the packet deframer: holds one received byte item.
// Depends on rpd_pkg for item_t.
module rpd_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rpd_pkg::item_t in_item,
    input  logic           advance,
    output logic           s1_valid,
    output rpd_pkg::item_t s1_item
);

    logic           valid_reg;
    logic           valid_next;
    rpd_pkg::item_t item_reg;
    logic           load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

// ----- src/rpd_parser.sv -----
// Packet state tracker: header decode, running CRC-8, length, trailer and address checks.
// Depends on rpd_pkg for item_t, cfg_t, result_t, status codes and crc8_update.
module rpd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  rpd_pkg::item_t   item,
    input  rpd_pkg::cfg_t    cfg,
    output logic             res_valid,
    output rpd_pkg::result_t res
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [15:0] POS_ID     = 16'd0;
    localparam logic [15:0] POS_DEST   = 16'd1;
    localparam logic [15:0] POS_SENDER = 16'd3;
    localparam logic [15:0] POS_LEN_LO = 16'd4;
    localparam logic [15:0] POS_LEN_HI = 16'd5;
    localparam logic [15:0] POS_HCRC   = 16'd6;

    logic [1:0]  phase_reg,    phase_next;
    logic [15:0] index_reg,    index_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [15:0] length_reg,   length_next;
    logic [7:0]  dest_reg,     dest_next;
    logic [7:0]  sender_reg,   sender_next;
    logic        ok_reg,       ok_next;

    always_comb
    begin
        logic [1:0]  ph;
        logic [15:0] idx;
        logic [7:0]  crc;
        logic [15:0] len;
        logic [7:0]  dest;
        logic [7:0]  sender;
        logic        ok;
        logic [7:0]  b;
        logic        emit;
        logic [2:0]  st;
        logic        len_good;

        ph       = phase_reg;
        idx      = index_reg;
        crc      = crc_reg;
        len      = length_reg;
        dest     = dest_reg;
        sender   = sender_reg;
        ok       = ok_reg;
        b        = item.rx_byte;
        emit     = 1'b0;
        st       = rpd_pkg::ST_ACCEPTED;
        len_good = 1'b0;

        if (fire)
        begin
            // Start flag aborts whatever was in progress
            if (item.frame_start)
            begin
                ph     = PH_HEADER;
                idx    = 16'd0;
                crc    = 8'd0;
                len    = 16'd0;
                dest   = 8'd0;
                sender = 8'd0;
                ok     = 1'b0;
            end

            if (ph == PH_HEADER)
            begin
                if (idx == POS_ID)
                    ok = ({1'b0, b} == ({1'b0, rpd_pkg::ID_BASE} + {1'b0, cfg.unit_id}));
                if (idx == POS_DEST)
                    dest = b;
                if (idx == POS_SENDER)
                    sender = b;
                if (idx == POS_LEN_LO)
                    len = {len[15:8], b};
                if (idx == POS_LEN_HI)
                    len = {b, len[7:0]};

                len_good = (len >= cfg.min_packet_length) && (len >= rpd_pkg::LEN_FLOOR)
                           && ({1'b0, len} < rpd_pkg::LEN_LIMIT);

                if (idx >= POS_HCRC)
                begin
                    if (crc != b || !ok)
                    begin
                        emit = 1'b1;
                        st   = rpd_pkg::ST_HDR_BAD;
                    end
                    else if (!len_good)
                    begin
                        emit = 1'b1;
                        st   = rpd_pkg::ST_LEN_BAD;
                    end
                    else
                    begin
                        // Header CRC byte doubles as packet CRC for the shortest packet
                        ok  = 1'b1;
                        crc = rpd_pkg::crc8_update(crc, b);
                        ph  = PH_BODY;
                    end
                end
                else
                begin
                    crc = rpd_pkg::crc8_update(crc, b);
                end
                idx = idx + 16'd1;
            end
            else if (ph == PH_BODY)
            begin
                if (({1'b0, idx} + 17'd2) == {1'b0, len})
                    ok = (crc == b);
                crc = rpd_pkg::crc8_update(crc, b);
                if (({1'b0, idx} + 17'd1) >= {1'b0, len})
                begin
                    emit = 1'b1;
                    if (b != cfg.end_code)
                        st = rpd_pkg::ST_NO_END;
                    else if (!ok)
                        st = rpd_pkg::ST_CRC_BAD;
                    else if (dest != cfg.own_address && dest != rpd_pkg::BCAST_ADR)
                        st = rpd_pkg::ST_NOT_ADDR;
                    else
                        st = rpd_pkg::ST_ACCEPTED;
                end
                idx = idx + 16'd1;
            end
            else
            begin
                // Stray byte outside a packet: drop
                ph = PH_IDLE;
            end

            if (emit)
                ph = PH_IDLE;
        end

        phase_next  = ph;
        index_next  = idx;
        crc_next    = crc;
        length_next = len;
        dest_next   = dest;
        sender_next = sender;
        ok_next     = ok;

        res_valid          = emit;
        res.status         = st;
        res.sender_address = sender;
        res.is_broadcast   = (dest == rpd_pkg::BCAST_ADR);
        res.packet_length  = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            index_reg  <= 16'd0;
            crc_reg    <= 8'd0;
            length_reg <= 16'd0;
            dest_reg   <= 8'd0;
            sender_reg <= 8'd0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            crc_reg    <= crc_next;
            length_reg <= length_next;
            dest_reg   <= dest_next;
            sender_reg <= sender_next;
            ok_reg     <= ok_next;
        end
    end

endmodule

// ----- src/rpd_out_stage.sv -----
// Result register of the packet deframer with valid/ready toward the consumer.
// Depends on rpd_pkg for result_t.
module rpd_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  rpd_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output rpd_pkg::result_t out_res
);

    logic             valid_reg;
    logic             valid_next;
    rpd_pkg::result_t res_reg;

    // Pipeline moves when the result slot is empty or being taken
    assign advance = !valid_reg || out_ready;

    always_comb
    begin
        if (advance)
            valid_next = res_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for rs485_packet_deframer_crc8: builds framed packets, predicts a
// status item for each packet its CRC-8 tracker closes and checks every result.
// Depends on src/rpd_pkg.sv and src/rs485_packet_deframer_crc8.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL     = 400;
    localparam int CALM_FROM     = 300;
    localparam int PKTS_PER_CFG  = 8;
    localparam int LONG_HOLD     = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT   = 1000;
    localparam int NO_TYPED      = -1;
    localparam int PLAN_ROWS     = 25;

    typedef enum logic [1:0] {LN_IDLE, LN_HEADER, LN_BODY} line_phase_t;

    typedef enum int {
        PK_GOOD, PK_BAD_ID, PK_BAD_HCRC, PK_BAD_BOTH, PK_BAD_PCRC,
        PK_BAD_END, PK_CUT, PK_NOISE, PK_CFG
    } pkt_kind_t;

    // For PK_CFG rows, dest carries the register index and len the write data
    typedef struct {
        pkt_kind_t  kind;
        int         len;
        logic [7:0] dest;
        logic [7:0] sender;
        int         want_status;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [7:0]                    rx_byte;
    logic                          frame_start;
    logic                          out_valid;
    logic                          out_ready;
    logic [2:0]                    status;
    logic [7:0]                    sender_address;
    logic                          is_broadcast;
    logic [15:0]                   packet_length;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;

    // Mirror of the registers and of the packet tracker
    rpd_pkg::cfg_t cfg_mirror;
    line_phase_t   ln_phase;
    logic [15:0]   ln_index;
    logic [7:0]    ln_crc;
    logic [15:0]   ln_len;
    logic [7:0]    ln_dest;
    logic [7:0]    ln_sender;
    logic          ln_ok;

    rpd_pkg::result_t pending_status_q[$];
    plan_row_t        directed_plan[PLAN_ROWS];
    int               mismatch_count = 0;
    int               bytes_sent = 0;
    int               quiet_cycles = 0;
    bit               calm = 1'b0;
    bit               hold_rx = 1'b0;

    rs485_packet_deframer_crc8 u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .sender_address (sender_address),
        .is_broadcast   (is_broadcast),
        .packet_length  (packet_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    // Bitwise LSB-first form of the reflected CRC-8
    function automatic logic [7:0] crc_shift_in(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] acc;
        logic       fb;
        acc = c;
        for (int i = 0; i < 8; i++)
        begin
            fb = acc[0] ^ d[i];
            acc = acc >> 1;
            if (fb)
                acc = acc ^ rpd_pkg::CRC_POLY;
        end
        return acc;
    endfunction

    function automatic rpd_pkg::result_t close_packet(input logic [2:0] st);
        rpd_pkg::result_t r;
        r.status = st;
        r.sender_address = ln_sender;
        r.is_broadcast = (ln_dest == rpd_pkg::BCAST_ADR);
        r.packet_length = ln_len;
        ln_phase = LN_IDLE;
        return r;
    endfunction

    task automatic track_packet_byte(input logic [7:0] b, input logic s,
                                     output bit fired, output rpd_pkg::result_t r);
        logic [15:0] idx;
        int          len;
        fired = 1'b0;
        r = '0;
        if (s)
        begin
            ln_phase = LN_HEADER;
            ln_index = '0;
            ln_crc = '0;
            ln_len = '0;
            ln_dest = '0;
            ln_sender = '0;
            ln_ok = 1'b0;
        end
        else if (ln_phase != LN_HEADER && ln_phase != LN_BODY)
        begin
            ln_phase = LN_IDLE;
            return;
        end
        idx = ln_index;
        ln_index = idx + 16'd1;
        len = int'(ln_len);
        if (ln_phase == LN_HEADER)
        begin
            case (idx)
                16'd0: ln_ok = ({1'b0, b} == 9'(rpd_pkg::ID_BASE) + 9'(cfg_mirror.unit_id));
                16'd1: ln_dest = b;
                16'd3: ln_sender = b;
                16'd4: ln_len[7:0] = b;
                16'd5: ln_len[15:8] = b;
                default: ;
            endcase
            len = int'(ln_len);
            if (idx >= 16'd6)
            begin
                if (ln_crc != b || !ln_ok)
                begin
                    r = close_packet(rpd_pkg::ST_HDR_BAD);
                    fired = 1'b1;
                end
                else if (len < int'(cfg_mirror.min_packet_length) ||
                         len < int'(rpd_pkg::LEN_FLOOR) ||
                         len + 6 >= rpd_pkg::RX_BUFFER_SIZE)
                begin
                    r = close_packet(rpd_pkg::ST_LEN_BAD);
                    fired = 1'b1;
                end
                else
                begin
                    ln_ok = 1'b1;
                    ln_crc = crc_shift_in(ln_crc, b);
                    ln_phase = LN_BODY;
                end
            end
            else
                ln_crc = crc_shift_in(ln_crc, b);
            return;
        end
        if (int'(idx) + 2 == len)
            ln_ok = (ln_crc == b);
        ln_crc = crc_shift_in(ln_crc, b);
        if (int'(idx) + 1 >= len)
        begin
            fired = 1'b1;
            if (b != cfg_mirror.end_code)
                r = close_packet(rpd_pkg::ST_NO_END);
            else if (!ln_ok)
                r = close_packet(rpd_pkg::ST_CRC_BAD);
            else if (ln_dest != cfg_mirror.own_address && ln_dest != rpd_pkg::BCAST_ADR)
                r = close_packet(rpd_pkg::ST_NOT_ADDR);
            else
                r = close_packet(rpd_pkg::ST_ACCEPTED);
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic s, input bit use_typed,
                             input rpd_pkg::result_t want);
        bit               fired;
        rpd_pkg::result_t r;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_packet_byte(b, s, fired, r);
        if (fired)
            pending_status_q.push_back(use_typed ? want : r);
        bytes_sent++;
    endtask

    task automatic send_packet(input pkt_kind_t kind, input int len, input logic [7:0] dest,
                               input logic [7:0] sender, input int want_status);
        logic [7:0]       pkt[$];
        logic [7:0]       crc;
        logic [7:0]       v;
        logic [15:0]      lenw;
        int               n;
        bit               len_ok;
        rpd_pkg::result_t want;
        lenw = 16'(len);
        want.status = 3'(want_status);
        want.sender_address = sender;
        want.is_broadcast = (dest == rpd_pkg::BCAST_ADR);
        want.packet_length = lenw;
        if (kind == PK_NOISE)
        begin
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom), 1'b0, 1'b0, want);
            return;
        end
        len_ok = len >= int'(cfg_mirror.min_packet_length) &&
                 len >= int'(rpd_pkg::LEN_FLOOR) &&
                 len + 6 < rpd_pkg::RX_BUFFER_SIZE;
        n = len_ok ? len : 7 + $urandom_range(0, 3);
        // Stop short; the next frame start aborts what was sent
        if (kind == PK_CUT)
            n = $urandom_range(1, n - 1);
        crc = '0;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
            begin
                v = 8'(rpd_pkg::ID_BASE + cfg_mirror.unit_id);
                if (kind == PK_BAD_ID || kind == PK_BAD_BOTH)
                    v = v ^ 8'($urandom_range(1, 255));
            end
            else if (i == 1)
                v = dest;
            else if (i == 3)
                v = sender;
            else if (i == 4)
                v = lenw[7:0];
            else if (i == 5)
                v = lenw[15:8];
            else if (i == 6)
            begin
                v = crc;
                if (kind == PK_BAD_HCRC || kind == PK_BAD_BOTH)
                    v = v ^ 8'($urandom_range(1, 255));
            end
            else if (i == len - 2)
            begin
                v = crc;
                if (kind == PK_BAD_PCRC)
                    v = v ^ 8'($urandom_range(1, 255));
            end
            else if (i == len - 1)
            begin
                v = cfg_mirror.end_code;
                if (kind == PK_BAD_END)
                    v = v ^ 8'($urandom_range(1, 255));
            end
            else
                v = 8'($urandom);
            pkt.push_back(v);
            crc = crc_shift_in(crc, v);
        end
        foreach (pkt[i])
            send_byte(pkt[i], i == 0, want_status != NO_TYPED, want);
    endtask

    // Lower valid and hold until the block has nothing left in flight
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            rpd_pkg::CFG_UNIT_ID:  cfg_mirror.unit_id = data[7:0];
            rpd_pkg::CFG_OWN_ADDR: cfg_mirror.own_address = data[7:0];
            rpd_pkg::CFG_MIN_LEN:  cfg_mirror.min_packet_length = data;
            rpd_pkg::CFG_END_CODE: cfg_mirror.end_code = data[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status_q.size() == 0)
                flag_mismatch("result with none pending", int'(status), 0);
            else
            begin
                rpd_pkg::result_t want;
                want = pending_status_q.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", int'(status), int'(want.status));
                if (sender_address !== want.sender_address)
                    flag_mismatch("sender_address", int'(sender_address),
                                  int'(want.sender_address));
                if (is_broadcast !== want.is_broadcast)
                    flag_mismatch("is_broadcast", int'(is_broadcast),
                                  int'(want.is_broadcast));
                if (packet_length !== want.packet_length)
                    flag_mismatch("packet_length", int'(packet_length),
                                  int'(want.packet_length));
            end
        end
    end

    // Watchdog: end the run after a long stretch with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     quiet_cycles, pending_status_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, one long hold on request, none once calm
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int          phase_no;
        int          r;
        int          len;
        int          lo;
        pkt_kind_t   kind;
        logic [7:0]  dest;
        logic [7:0]  unit_v;
        logic [7:0]  own_v;
        logic [7:0]  end_v;
        logic [15:0] min_v;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        frame_start <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cfg_mirror.unit_id = 8'd0;
        cfg_mirror.own_address = 8'd1;
        cfg_mirror.min_packet_length = 16'd9;
        cfg_mirror.end_code = 8'd4;
        ln_phase = LN_IDLE;
        ln_index = '0;
        ln_crc = '0;
        ln_len = '0;
        ln_dest = '0;
        ln_sender = '0;
        ln_ok = 1'b0;

        directed_plan = '{
            '{PK_GOOD,     9,      8'h01, 8'hA5, int'(rpd_pkg::ST_ACCEPTED)},
            '{PK_GOOD,     9,      8'hFF, 8'h00, int'(rpd_pkg::ST_ACCEPTED)},
            '{PK_GOOD,     10,     8'h00, 8'hFF, int'(rpd_pkg::ST_NOT_ADDR)},
            '{PK_GOOD,     8,      8'h01, 8'h3C, int'(rpd_pkg::ST_LEN_BAD)},
            '{PK_GOOD,     1018,   8'h01, 8'h11, int'(rpd_pkg::ST_LEN_BAD)},
            '{PK_GOOD,     65535,  8'hFF, 8'h22, int'(rpd_pkg::ST_LEN_BAD)},
            '{PK_GOOD,     0,      8'h01, 8'h23, int'(rpd_pkg::ST_LEN_BAD)},
            '{PK_BAD_ID,   9,      8'h01, 8'h33, int'(rpd_pkg::ST_HDR_BAD)},
            '{PK_BAD_HCRC, 12,     8'h01, 8'h44, int'(rpd_pkg::ST_HDR_BAD)},
            '{PK_BAD_BOTH, 65535,  8'h01, 8'h55, int'(rpd_pkg::ST_HDR_BAD)},
            '{PK_BAD_PCRC, 12,     8'h01, 8'h66, int'(rpd_pkg::ST_CRC_BAD)},
            '{PK_BAD_END,  12,     8'h01, 8'h77, int'(rpd_pkg::ST_NO_END)},
            '{PK_NOISE,    5,      8'h00, 8'h00, NO_TYPED},
            '{PK_CUT,      12,     8'h01, 8'h88, NO_TYPED},
            '{PK_GOOD,     40,     8'h01, 8'h99, int'(rpd_pkg::ST_ACCEPTED)},
            '{PK_CFG,      0,      8'(rpd_pkg::CFG_MIN_LEN),  8'h00, NO_TYPED},
            '{PK_GOOD,     8,      8'h01, 8'h5A, int'(rpd_pkg::ST_ACCEPTED)},
            '{PK_CFG,      239,    8'(rpd_pkg::CFG_UNIT_ID),  8'h00, NO_TYPED},
            '{PK_GOOD,     10,     8'hFF, 8'h12, int'(rpd_pkg::ST_ACCEPTED)},
            '{PK_CFG,      'hFFFF, 8'(rpd_pkg::CFG_UNIT_ID),  8'h00, NO_TYPED},
            '{PK_GOOD,     10,     8'h01, 8'h13, int'(rpd_pkg::ST_HDR_BAD)},
            '{PK_CFG,      'hFF00, 8'(rpd_pkg::CFG_OWN_ADDR), 8'h00, NO_TYPED},
            '{PK_CFG,      'h00FF, 8'(rpd_pkg::CFG_END_CODE), 8'h00, NO_TYPED},
            '{PK_CFG,      0,      8'(rpd_pkg::CFG_UNIT_ID),  8'h00, NO_TYPED},
            '{PK_GOOD,     9,      8'h00, 8'h14, int'(rpd_pkg::ST_ACCEPTED)}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == PK_CFG)
            begin
                drain_and_settle();
                write_reg(directed_plan[i].dest[rpd_pkg::CFG_IDX_W-1:0],
                          16'(directed_plan[i].len));
            end
            else
                send_packet(directed_plan[i].kind, directed_plan[i].len, directed_plan[i].dest,
                            directed_plan[i].sender, directed_plan[i].want_status);
        end

        phase_no = 0;
        while (bytes_sent < ITEM_GOAL)
        begin
            // First settings are the extremes, then random ones
            unit_v = 8'($urandom_range(0, 239));
            own_v = 8'($urandom);
            end_v = 8'($urandom);
            r = $urandom_range(0, 9);
            if (r < 4)
                min_v = 16'($urandom_range(0, 16));
            else if (r == 4)
                min_v = 16'd0;
            else if (r == 5)
                min_v = 16'd8;
            else if (r == 6)
                min_v = 16'd9;
            else if (r == 7)
                min_v = 16'($urandom_range(0, 40));
            else if (r == 8)
                min_v = 16'd1018;
            else
                min_v = 16'($urandom);
            if ($urandom_range(0, 19) == 0)
                unit_v = 8'($urandom_range(240, 255));
            case (phase_no)
                0:
                begin
                    unit_v = 8'd0;
                    own_v = 8'h00;
                    min_v = 16'd0;
                    end_v = 8'h00;
                end
                1:
                begin
                    unit_v = 8'd239;
                    own_v = 8'hFF;
                    min_v = 16'd8;
                    end_v = 8'hFF;
                end
                2: min_v = 16'hFFFF;
                3:
                begin
                    unit_v = 8'($urandom_range(240, 255));
                    min_v = 16'd9;
                end
                default: ;
            endcase
            drain_and_settle();
            write_reg(rpd_pkg::CFG_UNIT_ID, {8'($urandom), unit_v});
            write_reg(rpd_pkg::CFG_OWN_ADDR, {8'($urandom), own_v});
            write_reg(rpd_pkg::CFG_MIN_LEN, min_v);
            write_reg(rpd_pkg::CFG_END_CODE, {8'($urandom), end_v});

            for (int k = 0; k < PKTS_PER_CFG; k++)
            begin
                calm = (bytes_sent >= CALM_FROM);
                if (phase_no == 0 && k == 2)
                    hold_rx = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 55)
                    kind = PK_GOOD;
                else if (r < 61)
                    kind = PK_BAD_ID;
                else if (r < 67)
                    kind = PK_BAD_HCRC;
                else if (r < 70)
                    kind = PK_BAD_BOTH;
                else if (r < 78)
                    kind = PK_BAD_PCRC;
                else if (r < 86)
                    kind = PK_BAD_END;
                else if (r < 93)
                    kind = PK_CUT;
                else
                    kind = PK_NOISE;
                lo = (int'(min_v) > 8) ? int'(min_v) : 8;
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = (lo > 1017) ? lo : lo + $urandom_range(0, 12);
                else if (r < 85)
                    len = $urandom_range(0, 7);
                else if (r < 90)
                    len = $urandom_range(1018, 65535);
                else
                    len = $urandom_range(20, 200);
                if (len > 1017 && lo <= 1017 && r < 80)
                    len = 1017;
                r = $urandom_range(0, 9);
                dest = (r < 5) ? own_v : (r < 7) ? rpd_pkg::BCAST_ADR : 8'($urandom);
                if (kind == PK_NOISE)
                    len = $urandom_range(1, 6);
                send_packet(kind, len, dest, 8'($urandom), NO_TYPED);
            end
            phase_no++;
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
